/* src/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/ipvrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 receive filter package
// Shared constants, verdict codes and the per-packet record type.
// ----------------------------------------------------------------------------
package ipvrf_pkg;

    // Default width of the received-byte counter.
    localparam int COUNT_BITS_DEF = 16;
    // Width of the counter field carried in a packet record (largest counter).
    localparam int COUNT_W_MAX    = 16;
    // Entries in the queue between the parser and the verdict stage.
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [5:0]  HDR_MIN    = 6'd20;
    localparam logic [15:0] UDP_HDR    = 16'd8;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [31:0] BCAST_ADDR = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        VERDICT_ICMP      = 3'd0,
        VERDICT_UDP       = 3'd1,
        VERDICT_OTHER     = 3'd2,
        VERDICT_SHORT     = 3'd3,
        VERDICT_BAD_IHL   = 3'd4,
        VERDICT_NOT_OURS  = 3'd5,
        VERDICT_BAD_CSUM  = 3'd6,
        VERDICT_UDP_SHORT = 3'd7
    } verdict_t;

    // Everything the parser learned about one packet.
    typedef struct packed {
        logic [COUNT_W_MAX-1:0] count;
        logic [5:0]             hdr_bytes;
        logic [15:0]            total_len;
        logic [7:0]             proto;
        logic [31:0]            src;
        logic [31:0]            dst;
        logic [15:0]            sum;
        logic [15:0]            csum;
        logic [47:0]            udp;
    } pkt_rec_t;

endpackage

/* src/ipvrf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 receive filter byte parser
// Captures header fields and header sum one byte per cycle unless q_full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipvrf_front #(
    parameter int COUNT_BITS = ipvrf_pkg::COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          data_byte,
    input  logic                last,
    input  logic                q_full,
    output logic                rec_push,
    output ipvrf_pkg::pkt_rec_t rec
);

    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] byte_index_reg, byte_index_next;
    logic [5:0]            hdr_reg, hdr_next;
    logic [15:0]           tlen_reg, tlen_next;
    logic [7:0]            proto_reg, proto_next;
    logic [31:0]           src_reg, src_next;
    logic [31:0]           dst_reg, dst_next;
    logic [15:0]           sum_reg, sum_next;
    logic [15:0]           csum_reg, csum_next;
    logic [7:0]            pend_reg, pend_next;
    logic [47:0]           udp_reg, udp_next;

    logic                  acc;
    logic [COUNT_BITS-1:0] idx;
    logic [COUNT_BITS-1:0] hdr_ext;
    logic [16:0]           sum_wide;

    assign full     = q_full;
    assign acc      = push && !q_full;
    assign rec_push = acc && last;
    assign idx      = byte_index_reg;
    assign hdr_ext  = COUNT_BITS'(hdr_reg);
    assign sum_wide = {1'b0, sum_reg} + {1'b0, pend_reg, data_byte};

    always_comb
    begin
        hdr_next   = hdr_reg;
        tlen_next  = tlen_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        sum_next   = sum_reg;
        csum_next  = csum_reg;
        pend_next  = pend_reg;
        udp_next   = udp_reg;

        if (idx == '0)
        begin
            hdr_next = {data_byte[3:0], 2'b00};
        end

        // Header sum; the checksum word itself is skipped.
        if ((idx == '0) || (idx < hdr_ext))
        begin
            if (!idx[0])
            begin
                pend_next = data_byte;
            end
            else if (idx != COUNT_BITS'(11))
            begin
                sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
            end
        end

        if ((idx == COUNT_BITS'(2)) || (idx == COUNT_BITS'(3)))
        begin
            tlen_next = {tlen_reg[7:0], data_byte};
        end
        else if (idx == COUNT_BITS'(9))
        begin
            proto_next = data_byte;
        end
        else if ((idx == COUNT_BITS'(10)) || (idx == COUNT_BITS'(11)))
        begin
            csum_next = {csum_reg[7:0], data_byte};
        end
        else if ((idx >= COUNT_BITS'(12)) && (idx <= COUNT_BITS'(15)))
        begin
            src_next = {src_reg[23:0], data_byte};
        end
        else if ((idx >= COUNT_BITS'(16)) && (idx <= COUNT_BITS'(19)))
        begin
            dst_next = {dst_reg[23:0], data_byte};
        end

        // First six bytes after a valid header are the UDP ports and length.
        if ((hdr_reg >= ipvrf_pkg::HDR_MIN) && (idx >= hdr_ext)
            && ((idx - hdr_ext) < COUNT_BITS'(6)))
        begin
            udp_next = {udp_reg[39:0], data_byte};
        end

        byte_index_next = (idx != CMAX) ? idx + COUNT_BITS'(1) : idx;
    end

    always_comb
    begin
        rec.count     = ipvrf_pkg::COUNT_W_MAX'(byte_index_next);
        rec.hdr_bytes = hdr_next;
        rec.total_len = tlen_next;
        rec.proto     = proto_next;
        rec.src       = src_next;
        rec.dst       = dst_next;
        rec.sum       = sum_next;
        rec.csum      = csum_next;
        rec.udp       = udp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            hdr_reg        <= '0;
            tlen_reg       <= '0;
            proto_reg      <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
            sum_reg        <= '0;
            csum_reg       <= '0;
            pend_reg       <= '0;
            udp_reg        <= '0;
        end
        else if (acc)
        begin
            if (last)
            begin
                byte_index_reg <= '0;
                hdr_reg        <= '0;
                tlen_reg       <= '0;
                proto_reg      <= '0;
                src_reg        <= '0;
                dst_reg        <= '0;
                sum_reg        <= '0;
                csum_reg       <= '0;
                pend_reg       <= '0;
                udp_reg        <= '0;
            end
            else
            begin
                byte_index_reg <= byte_index_next;
                hdr_reg        <= hdr_next;
                tlen_reg       <= tlen_next;
                proto_reg      <= proto_next;
                src_reg        <= src_next;
                dst_reg        <= dst_next;
                sum_reg        <= sum_next;
                csum_reg       <= csum_next;
                pend_reg       <= pend_next;
                udp_reg        <= udp_next;
            end
        end
    end

    // A finished packet must leave the parser ready for a fresh header.
    `ASSERT_CLK(a_restart_after_last, rec_push |=> (byte_index_reg == '0 && sum_reg == '0), "parser not cleared after last byte")

endmodule

/* src/ipvrf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 receive filter record queue
// Short queue of packet records between the parser and the verdict stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipvrf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  ipvrf_pkg::pkt_rec_t wdata,
    output logic                full,
    input  logic                rd,
    output ipvrf_pkg::pkt_rec_t rdata,
    output logic                empty
);

    localparam int DEPTH = ipvrf_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    ipvrf_pkg::pkt_rec_t entry_reg [DEPTH];
    logic [PW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                do_wr, do_rd;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    `ASSERT_CLK(a_cnt_bound, cnt_reg <= CW'(DEPTH), "queue count above depth")
    `ASSERT_CLK(a_no_lost_record, wr |-> !full, "record written into a full queue")

endmodule

/* src/ipvrf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 receive filter verdict stage
// Judges one packet record and holds the result until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipvrf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         local_addr,
    input  logic                rec_valid,
    input  ipvrf_pkg::pkt_rec_t rec,
    output logic                rec_pop,
    output logic                empty,
    input  logic                pop,
    output logic [2:0]          verdict,
    output logic [31:0]         source_addr,
    output logic [7:0]          proto_num,
    output logic [5:0]          payload_offset,
    output logic [15:0]         body_len,
    output logic [15:0]         udp_src_port,
    output logic [15:0]         udp_dst_port,
    output logic [15:0]         udp_data_len
);

    logic                out_valid_reg;
    ipvrf_pkg::verdict_t verdict_reg, verdict_next;
    logic [31:0]         src_reg, src_next;
    logic [7:0]          proto_reg, proto_next;
    logic [5:0]          offset_reg, offset_next;
    logic [15:0]         plen_reg, plen_next;
    logic [15:0]         sport_reg, sport_next;
    logic [15:0]         dport_reg, dport_next;
    logic [15:0]         dlen_reg, dlen_next;

    logic                load;
    logic [15:0]         hdr16, cnt16, plen, after_hdr, udp_len;

    assign load    = rec_valid && (!out_valid_reg || pop);
    assign rec_pop = load;
    assign empty   = !out_valid_reg;

    assign hdr16     = 16'(rec.hdr_bytes);
    assign cnt16     = 16'(rec.count);
    assign plen      = (rec.total_len > hdr16) ? rec.total_len - hdr16 : 16'd0;
    assign after_hdr = cnt16 - hdr16;
    assign udp_len   = rec.udp[15:0];

    always_comb
    begin
        if (cnt16 < 16'(ipvrf_pkg::HDR_MIN))
        begin
            verdict_next = ipvrf_pkg::VERDICT_SHORT;
        end
        else if (rec.hdr_bytes < ipvrf_pkg::HDR_MIN)
        begin
            verdict_next = ipvrf_pkg::VERDICT_BAD_IHL;
        end
        else if (cnt16 < hdr16)
        begin
            verdict_next = ipvrf_pkg::VERDICT_SHORT;
        end
        else if ((rec.dst != local_addr) && (rec.dst != ipvrf_pkg::BCAST_ADDR))
        begin
            verdict_next = ipvrf_pkg::VERDICT_NOT_OURS;
        end
        else if (~rec.sum != rec.csum)
        begin
            verdict_next = ipvrf_pkg::VERDICT_BAD_CSUM;
        end
        else if (rec.proto == ipvrf_pkg::PROTO_ICMP)
        begin
            verdict_next = ipvrf_pkg::VERDICT_ICMP;
        end
        else if (rec.proto == ipvrf_pkg::PROTO_UDP)
        begin
            if ((plen < ipvrf_pkg::UDP_HDR) || (after_hdr < ipvrf_pkg::UDP_HDR))
            begin
                verdict_next = ipvrf_pkg::VERDICT_UDP_SHORT;
            end
            else
            begin
                verdict_next = ipvrf_pkg::VERDICT_UDP;
            end
        end
        else
        begin
            verdict_next = ipvrf_pkg::VERDICT_OTHER;
        end

        src_next    = '0;
        proto_next  = '0;
        offset_next = '0;
        plen_next   = '0;
        sport_next  = '0;
        dport_next  = '0;
        dlen_next   = '0;

        case (verdict_next)
            ipvrf_pkg::VERDICT_ICMP,
            ipvrf_pkg::VERDICT_OTHER,
            ipvrf_pkg::VERDICT_UDP_SHORT:
            begin
                src_next    = rec.src;
                proto_next  = rec.proto;
                offset_next = rec.hdr_bytes;
                plen_next   = plen;
            end
            ipvrf_pkg::VERDICT_UDP:
            begin
                src_next    = rec.src;
                proto_next  = rec.proto;
                offset_next = rec.hdr_bytes;
                plen_next   = plen;
                sport_next  = rec.udp[47:32];
                dport_next  = rec.udp[31:16];
                dlen_next   = (udp_len > ipvrf_pkg::UDP_HDR) ?
                              udp_len - ipvrf_pkg::UDP_HDR : 16'd0;
            end
            default:
            begin
                src_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= verdict_next;
            src_reg     <= src_next;
            proto_reg   <= proto_next;
            offset_reg  <= offset_next;
            plen_reg    <= plen_next;
            sport_reg   <= sport_next;
            dport_reg   <= dport_next;
            dlen_reg    <= dlen_next;
        end
    end

    assign verdict        = verdict_reg;
    assign source_addr    = src_reg;
    assign proto_num      = proto_reg;
    assign payload_offset = offset_reg;
    assign body_len       = plen_reg;
    assign udp_src_port   = sport_reg;
    assign udp_dst_port   = dport_reg;
    assign udp_data_len   = dlen_reg;

    // Port fields are only meaningful for an accepted UDP datagram.
    `ASSERT_CLK(a_udp_fields_zero, (out_valid_reg && verdict_reg != ipvrf_pkg::VERDICT_UDP) |-> (sport_reg == '0 && dport_reg == '0 && dlen_reg == '0), "UDP fields set on non-UDP verdict")

endmodule

/* src/ipv4_receive_filter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 receive filter top level
// Checks IPv4 headers byte by byte and reports one verdict per packet.
// ----------------------------------------------------------------------------
// The filter takes one packet byte per clock while full is low, in wire order
// on the push side, with last marking the final byte, and produces exactly
// one result request per packet. The final byte's record passes through the
// record queue into the result register of the verdict stage, which takes it
// once free. The byte parser does all its work on a byte as it takes it, so
// the sustained rate is one byte every cycle; full rises only when the
// two-entry record queue between the parser and the verdict stage holds two
// records, which happens only when results are not being popped, and while
// it is high no byte of any packet is taken. Each result request carries a
// verdict (ICMP, UDP, other protocol, too short, bad header length, not for
// this host, bad checksum, or UDP header short), together with the source
// address, protocol, header length, payload length and, for UDP only, the
// ports and data length. Rejected packets other than UDP header short report
// zero in every field but the verdict. The host address lives in a single
// APB register at byte offset 0; packets addressed to it or to the broadcast
// address are accepted. Change it only while no packet is in flight. There is
// no clearing pass after reset: the block is ready once rst_n is released.
// ----------------------------------------------------------------------------

module ipv4_receive_filter_top #(
    parameter int COUNT_BITS = ipvrf_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Byte input.
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last,
    // Result output.
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  verdict,
    output logic [31:0] source_addr,
    output logic [7:0]  proto_num,
    output logic [5:0]  payload_offset,
    output logic [15:0] body_len,
    output logic [15:0] udp_src_port,
    output logic [15:0] udp_dst_port,
    output logic [15:0] udp_data_len,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ADDR_LOCAL_ADDR = 2'd0;

    logic [31:0]         local_addr_reg;
    logic                cfg_wr;

    logic                q_full, q_empty, q_wr, q_rd;
    ipvrf_pkg::pkt_rec_t q_wdata, q_rdata;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == ADDR_LOCAL_ADDR) ? local_addr_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg <= '0;
        end
        else if (cfg_wr && (paddr == ADDR_LOCAL_ADDR))
        begin
            local_addr_reg <= pwdata;
        end
    end

    // Front: per-byte header capture and running ones'-complement sum.
    ipvrf_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .last      (last),
        .q_full    (q_full),
        .rec_push  (q_wr),
        .rec       (q_wdata)
    );

    // Record queue lets the parser keep taking bytes while results wait.
    ipvrf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Back: verdict decision and the registered result.
    ipvrf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .local_addr     (local_addr_reg),
        .rec_valid      (!q_empty),
        .rec            (q_rdata),
        .rec_pop        (q_rd),
        .empty          (empty),
        .pop            (pop),
        .verdict        (verdict),
        .source_addr    (source_addr),
        .proto_num      (proto_num),
        .payload_offset (payload_offset),
        .body_len       (body_len),
        .udp_src_port   (udp_src_port),
        .udp_dst_port   (udp_dst_port),
        .udp_data_len   (udp_data_len)
    );

endmodule

/* test/ipv4_receive_filter_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 receive filter checker
// Watches the byte, result and register channels of the filter, predicts each
// packet verdict and compares every popped result against it.
// ----------------------------------------------------------------------------

module ipv4_receive_filter_checker
    import ipvrf_pkg::*;
#(
    parameter logic [1:0] HOST_REG_ADDR = 2'd0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  verdict,
    input  logic [31:0] source_addr,
    input  logic [7:0]  proto_num,
    input  logic [5:0]  payload_offset,
    input  logic [15:0] body_len,
    input  logic [15:0] udp_src_port,
    input  logic [15:0] udp_dst_port,
    input  logic [15:0] udp_data_len,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          result_count
);

    localparam logic [15:0] COUNT_MAX = 16'((1 << COUNT_BITS_DEF) - 1);

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] src;
        logic [7:0]  proto;
        logic [5:0]  offset;
        logic [15:0] plen;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] dlen;
    } verdict_rec_t;

    verdict_rec_t pending_verdicts[$];

    // Host address and the per-packet parse state.
    logic [31:0] host_addr;
    logic [15:0] byte_cnt;
    logic [5:0]  hdr_len;
    logic [15:0] tot_len;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] hsum;
    logic [15:0] csum_field;
    logic [7:0]  hi_byte;
    logic [47:0] udp_hdr;

    task automatic clear_packet();
        byte_cnt   = '0;
        hdr_len    = '0;
        tot_len    = '0;
        proto      = '0;
        src        = '0;
        dst        = '0;
        hsum       = '0;
        csum_field = '0;
        hi_byte    = '0;
        udp_hdr    = '0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Takes one accepted byte; on the last byte of a packet it queues the
    // verdict record the filter must produce.
    task automatic absorb_byte(input logic [7:0] b, input logic is_last);
        logic [15:0]  idx;
        logic [15:0]  cnt;
        logic [16:0]  wsum;
        logic [15:0]  plen;
        verdict_t     v;
        verdict_rec_t rec;

        idx = byte_cnt;
        if (idx == 16'd0)
            hdr_len = {b[3:0], 2'b00};

        // Header words are summed with end-around carry; the checksum word
        // itself is left out of the sum.
        if (idx == 16'd0 || idx < hdr_len)
        begin
            if (!idx[0])
                hi_byte = b;
            else if (idx != 16'd11)
            begin
                wsum = {1'b0, hsum} + {1'b0, hi_byte, b};
                hsum = wsum[15:0] + {15'd0, wsum[16]};
            end
        end

        if (idx == 16'd2 || idx == 16'd3)
            tot_len = {tot_len[7:0], b};
        else if (idx == 16'd9)
            proto = b;
        else if (idx == 16'd10 || idx == 16'd11)
            csum_field = {csum_field[7:0], b};
        else if (idx >= 16'd12 && idx <= 16'd15)
            src = {src[23:0], b};
        else if (idx >= 16'd16 && idx <= 16'd19)
            dst = {dst[23:0], b};

        if (hdr_len >= HDR_MIN && idx >= hdr_len && (idx - hdr_len) < 16'd6)
            udp_hdr = {udp_hdr[39:0], b};

        cnt = (idx == COUNT_MAX) ? idx : idx + 16'd1;
        byte_cnt = cnt;

        if (is_last)
        begin
            if (cnt < HDR_MIN)
                v = VERDICT_SHORT;
            else if (hdr_len < HDR_MIN)
                v = VERDICT_BAD_IHL;
            else if (cnt < hdr_len)
                v = VERDICT_SHORT;
            else if (dst != host_addr && dst != BCAST_ADDR)
                v = VERDICT_NOT_OURS;
            else if (~hsum != csum_field)
                v = VERDICT_BAD_CSUM;
            else if (proto == PROTO_ICMP)
                v = VERDICT_ICMP;
            else if (proto == PROTO_UDP)
                v = VERDICT_UDP;
            else
                v = VERDICT_OTHER;

            plen = (tot_len > hdr_len) ? tot_len - hdr_len : 16'd0;
            if (v == VERDICT_UDP && (plen < UDP_HDR || cnt - hdr_len < UDP_HDR))
                v = VERDICT_UDP_SHORT;

            rec = '0;
            rec.verdict = v;
            if (v == VERDICT_ICMP || v == VERDICT_UDP || v == VERDICT_OTHER ||
                v == VERDICT_UDP_SHORT)
            begin
                rec.src    = src;
                rec.proto  = proto;
                rec.offset = hdr_len;
                rec.plen   = plen;
            end
            if (v == VERDICT_UDP)
            begin
                rec.sport = udp_hdr[47:32];
                rec.dport = udp_hdr[31:16];
                rec.dlen  = (udp_hdr[15:0] > UDP_HDR) ? udp_hdr[15:0] - UDP_HDR : 16'd0;
            end
            pending_verdicts.push_back(rec);
            clear_packet();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_rec_t want;
        if (!rst_n)
        begin
            clear_packet();
            host_addr = '0;
            pending_verdicts.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                result_count++;
                if (pending_verdicts.size() == 0)
                begin
                    $error("result popped with no packet outstanding (verdict %0d)",
                           verdict);
                    fail_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    check_field("verdict", want.verdict, verdict);
                    check_field("source_addr", want.src, source_addr);
                    check_field("proto_num", want.proto, proto_num);
                    check_field("payload_offset", want.offset, payload_offset);
                    check_field("body_len", want.plen, body_len);
                    check_field("udp_src_port", want.sport, udp_src_port);
                    check_field("udp_dst_port", want.dport, udp_dst_port);
                    check_field("udp_data_len", want.dlen, udp_data_len);
                end
            end
            if (push && !full)
                absorb_byte(data_byte, last);
            if (psel && penable && pready && paddr == HOST_REG_ADDR)
            begin
                if (pwrite)
                    host_addr = pwdata;
                else
                    check_field("prdata", host_addr, prdata);
            end
        end
    end

endmodule

/* test/ipv4_receive_filter_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 receive filter testbench
// Streams directed and randomized IPv4 packets through the filter under three
// flow-control regimes and host address settings; a checker module beside the
// filter predicts and compares every verdict.
// ----------------------------------------------------------------------------

module ipv4_receive_filter_top_tb;
    import ipvrf_pkg::*;

    // The host address register sits at byte offset 0 of the APB space.
    localparam logic [1:0] HOST_REG_ADDR = 2'd0;

    // Cycles after which the filter has surely settled once the last result
    // has been popped.
    localparam int SETTLE_CYCLES = 8;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        last;
    logic        empty;
    logic        pop;
    logic [2:0]  verdict;
    logic [31:0] source_addr;
    logic [7:0]  proto_num;
    logic [5:0]  payload_offset;
    logic [15:0] body_len;
    logic [15:0] udp_src_port;
    logic [15:0] udp_dst_port;
    logic [15:0] udp_data_len;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int result_count;

    // Idle percentages for the byte sender and the result receiver.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Packets sent and bytes sent so far; every packet yields one result.
    int packets_sent;
    int bytes_sent;

    // Host address currently programmed, used to aim packets at the filter.
    logic [31:0] host_addr_cfg;

    // Bytes of the packet being built, in wire order.
    logic [7:0] pkt_bytes[$];

    ipv4_receive_filter_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .last           (last),
        .empty          (empty),
        .pop            (pop),
        .verdict        (verdict),
        .source_addr    (source_addr),
        .proto_num      (proto_num),
        .payload_offset (payload_offset),
        .body_len       (body_len),
        .udp_src_port   (udp_src_port),
        .udp_dst_port   (udp_dst_port),
        .udp_data_len   (udp_data_len),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    ipv4_receive_filter_checker #(
        .HOST_REG_ADDR (HOST_REG_ADDR)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .last           (last),
        .empty          (empty),
        .pop            (pop),
        .verdict        (verdict),
        .source_addr    (source_addr),
        .proto_num      (proto_num),
        .payload_offset (payload_offset),
        .body_len       (body_len),
        .udp_src_port   (udp_src_port),
        .udp_dst_port   (udp_dst_port),
        .udp_data_len   (udp_data_len),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .fail_count     (fail_count),
        .result_count   (result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The receiver pops at random; pop may be high while nothing waits,
    // which the filter simply ignores.
    always @(posedge clk)
        pop <= ($urandom_range(99) >= recv_idle_pct);

    // A run that hangs, for example because a result never appears, ends
    // here as a failure.
    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

    // One APB access to the host address register, a write or a read. Each
    // access ends with the bus idle again so that the next access never drives
    // psel twice in one time step.
    task automatic host_reg_access(input logic is_write, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= HOST_REG_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_host(input logic [31:0] value);
        host_reg_access(1'b1, value);
        host_reg_access(1'b0, '0);
        host_addr_cfg = value;
    endtask

    // Offers one byte, possibly after some idle cycles, and returns once the
    // filter has taken it. Push stays high into the next byte when there is
    // no idle cycle, so back-to-back transfers happen at full rate.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        last      <= is_last;
        do @(posedge clk); while (full);
    endtask

    // Builds a packet into pkt_bytes. A negative total or UDP length means
    // the natural value for the bytes built; a bad checksum flips one bit.
    task automatic make_packet(input int ihl, input logic [7:0] proto,
                               input logic [31:0] src, input logic [31:0] dst,
                               input int data_len, input int tot_len,
                               input int udp_len, input bit bad_csum);
        int          hb;
        int          k;
        logic [15:0] tl;
        logic [15:0] ul;
        logic [15:0] run;
        logic [16:0] acc;
        logic [15:0] ck;

        hb = ihl * 4;
        tl = (tot_len < 0) ? 16'(hb + data_len + ((proto == PROTO_UDP) ? 8 : 0))
                           : 16'(tot_len);
        ul = (udp_len < 0) ? 16'(data_len + 8) : 16'(udp_len);

        pkt_bytes.delete();
        pkt_bytes.push_back({4'($urandom_range(15)), 4'(ihl)});
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(tl[15:8]);
        pkt_bytes.push_back(tl[7:0]);
        // Identification, flags, fragment offset and TTL are not inspected.
        for (k = 4; k < 9; k++)
            pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(proto);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'h00);
        for (k = 3; k >= 0; k--)
            pkt_bytes.push_back(src[8*k +: 8]);
        for (k = 3; k >= 0; k--)
            pkt_bytes.push_back(dst[8*k +: 8]);
        for (k = 20; k < hb; k++)
            pkt_bytes.push_back(8'($urandom));
        if (proto == PROTO_UDP)
        begin
            for (k = 0; k < 4; k++)
                pkt_bytes.push_back(8'($urandom));
            pkt_bytes.push_back(ul[15:8]);
            pkt_bytes.push_back(ul[7:0]);
            pkt_bytes.push_back(8'($urandom));
            pkt_bytes.push_back(8'($urandom));
        end
        for (k = 0; k < data_len; k++)
            pkt_bytes.push_back(8'($urandom));

        // Header checksum over the whole header, with the checksum word
        // counted as zero.
        if (hb >= 20)
        begin
            run = '0;
            for (k = 0; k < hb / 2; k++)
            begin
                if (k != 5)
                begin
                    acc = {1'b0, run} + {1'b0, pkt_bytes[2*k], pkt_bytes[2*k+1]};
                    run = acc[15:0] + {15'd0, acc[16]};
                end
            end
            ck = ~run;
            if (bad_csum)
                ck = ck ^ 16'(1 << $urandom_range(15));
            pkt_bytes[10] = ck[15:8];
            pkt_bytes[11] = ck[7:0];
        end
    endtask

    // Sends the first n bytes of the built packet, padding with random bytes
    // when n runs past its end, and marks byte n-1 as the last one.
    task automatic send_packet(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_byte((i < pkt_bytes.size()) ? pkt_bytes[i] : 8'($urandom), i == n - 1);
        packets_sent++;
        bytes_sent += n;
    endtask

    task automatic send_whole_packet();
        send_packet(pkt_bytes.size());
    endtask

    // Mostly well-formed packets aimed at this host or at broadcast, with a
    // minority of bad header lengths, foreign addresses, corrupted checksums,
    // odd length fields, truncations and trailing junk.
    task automatic random_packet();
        int          r;
        int          ihl;
        int          dlen;
        int          tl;
        int          ul;
        int          n;
        logic [7:0]  pr;
        logic [31:0] dst;

        r = $urandom_range(99);
        ihl = (r < 80) ? 5 : ((r < 95) ? $urandom_range(15, 6) : $urandom_range(4, 0));
        r = $urandom_range(99);
        pr = (r < 45) ? PROTO_UDP : ((r < 70) ? PROTO_ICMP : 8'($urandom));
        r = $urandom_range(99);
        dst = (r < 45) ? host_addr_cfg : ((r < 70) ? BCAST_ADDR : $urandom);
        dlen = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(24);
        tl = -1;
        if ($urandom_range(99) < 15)
            tl = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(40);
        ul = -1;
        if ($urandom_range(99) < 15)
            ul = $urandom_range(1) ? $urandom_range(65535) : $urandom_range(15);
        make_packet(ihl, pr, $urandom, dst, dlen, tl, ul, $urandom_range(99) < 8);

        n = pkt_bytes.size();
        r = $urandom_range(99);
        if (r < 8)
            n = $urandom_range(n, 1);
        else if (r < 13)
            n = n + $urandom_range(16, 1);
        send_packet(n);
    endtask

    // Waits until every packet has produced its result, then lets the
    // filter settle before its register is touched again.
    task automatic wait_all_results();
        while (result_count < packets_sent)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int unsigned s_idle, input int unsigned r_idle,
                                input int min_bytes, input int min_packets);
        int byte_goal;
        int pkt_goal;

        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        byte_goal = bytes_sent + min_bytes;
        pkt_goal  = packets_sent + min_packets;
        while (bytes_sent < byte_goal || packets_sent < pkt_goal)
            random_packet();
        push <= 1'b0;
        wait_all_results();
    endtask

    initial
    begin
        logic [31:0] h;

        rst_n         = 1'b0;
        push          <= 1'b0;
        data_byte     <= '0;
        last          <= 1'b0;
        pop           <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        packets_sent  = 0;
        bytes_sent    = 0;
        host_addr_cfg = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: light sender idling, heavy receiver stalls, an arbitrary
        // host address, and the directed packets first.
        send_idle_pct = 15;
        recv_idle_pct = 76;
        program_host($urandom);
        h = host_addr_cfg;

        // Packets far too short to hold a header: a lone byte and 19 bytes.
        make_packet(5, PROTO_ICMP, 32'h0, h, 0, -1, -1, 0);
        send_packet(1);
        send_packet(19);
        // Minimal clean ICMP with an all-zero source.
        make_packet(5, PROTO_ICMP, 32'h0, h, 0, -1, -1, 0);
        send_whole_packet();
        // UDP to broadcast from an all-ones source.
        make_packet(5, PROTO_UDP, 32'hFFFF_FFFF, BCAST_ADDR, 4, -1, -1, 0);
        send_whole_packet();
        // Largest header, carrying an unknown protocol.
        make_packet(15, 8'hFF, $urandom, h, 3, -1, -1, 0);
        send_whole_packet();
        // Header length fields below the legal minimum.
        make_packet(4, PROTO_ICMP, $urandom, h, 8, -1, -1, 0);
        send_whole_packet();
        make_packet(0, PROTO_UDP, $urandom, h, 8, -1, -1, 0);
        send_whole_packet();
        // Header claims 60 bytes but the packet ends at 40.
        make_packet(15, PROTO_ICMP, $urandom, h, 0, -1, -1, 0);
        send_packet(40);
        // Addressed to some other host.
        make_packet(5, PROTO_ICMP, $urandom, h + 32'd1, 0, -1, -1, 0);
        send_whole_packet();
        // Corrupted header checksum.
        make_packet(5, PROTO_UDP, $urandom, h, 4, -1, -1, 1);
        send_whole_packet();
        // Total length leaves under eight payload bytes: UDP header short.
        make_packet(5, PROTO_UDP, $urandom, h, 10, 24, -1, 0);
        send_whole_packet();
        // Total length below the header length: payload length saturates.
        make_packet(6, PROTO_UDP, $urandom, h, 10, 10, -1, 0);
        send_whole_packet();
        // Only five bytes follow the header.
        make_packet(5, PROTO_UDP, $urandom, h, 0, -1, -1, 0);
        send_packet(25);
        // UDP length field under eight: data length saturates at zero.
        make_packet(5, PROTO_UDP, $urandom, h, 2, -1, 3, 0);
        send_whole_packet();
        // Largest total length with protocol zero.
        make_packet(5, 8'h00, $urandom, h, 2, 65535, -1, 0);
        send_whole_packet();
        push <= 1'b0;
        wait_all_results();

        random_phase(15, 76, 130, 1);

        // Phase two: heavy sender idling, light receiver stalls, host zero.
        program_host(32'h0000_0000);
        random_phase(76, 15, 130, 1);

        // Phase three: no idling at all, host all ones, which coincides with
        // broadcast.
        program_host(32'hFFFF_FFFF);
        random_phase(0, 0, 130, 1);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
